/* rtl/priority_timer_task_scheduler_defines.svh */
// Assertion helpers for the timer scheduler.
`ifndef PRIORITY_TIMER_TASK_SCHEDULER_DEFINES_SVH
`define PRIORITY_TIMER_TASK_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("check failed");
`define PTS_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sequence check failed");
`else
`define PTS_ASSERT(lbl, cond)
`define PTS_ASSERT_NXT(lbl, pre, post)
`endif
`endif

/* rtl/pts_pkg.sv */
package pts_pkg;
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int TIME_W = 48;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DLY = 2'd1;
  localparam logic [1:0] ST_BAD_REP  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CHECK, S_EMIT} state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic fire;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic tick_go;
    logic scan_last;
    logic top_due;
    logic buf_full;
    logic out_last;
  } sts_t;
endpackage

/* rtl/pts_ctrl.sv */
`include "priority_timer_task_scheduler_defines.svh"
module pts_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  pts_pkg::sts_t   sts,
  output pts_pkg::cmd_t   cmd
);
  pts_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pts_pkg::S_IDLE: begin
        if (in_valid) state_next = sts.tick_go ? pts_pkg::S_SCAN : pts_pkg::S_EMIT;
      end
      pts_pkg::S_SCAN: begin
        if (sts.scan_last) state_next = pts_pkg::S_CHECK;
      end
      pts_pkg::S_CHECK: begin
        state_next = (sts.top_due && !sts.buf_full) ? pts_pkg::S_SCAN : pts_pkg::S_EMIT;
      end
      pts_pkg::S_EMIT: begin
        if (out_ready && sts.out_last) state_next = pts_pkg::S_IDLE;
      end
      default: state_next = pts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == pts_pkg::S_IDLE);
    out_valid   = (state == pts_pkg::S_EMIT);
    cmd.accept  = in_valid && in_ready;
    cmd.scan    = (state == pts_pkg::S_SCAN);
    cmd.fire    = (state == pts_pkg::S_CHECK) && sts.top_due && !sts.buf_full;
    cmd.advance = out_valid && out_ready;
  end

  `PTS_ASSERT(a_excl, !(in_ready && out_valid))
  `PTS_ASSERT_NXT(a_scan_end, state == pts_pkg::S_SCAN && sts.scan_last, state == pts_pkg::S_CHECK)
  `PTS_ASSERT_NXT(a_fire_rescan, cmd.fire, state == pts_pkg::S_SCAN)
endmodule

/* rtl/pts_dp.sv */
module pts_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  pts_pkg::cmd_t             cmd,
  output pts_pkg::sts_t             sts,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  logic [1:0]                mode,
  input  logic [7:0]                task_id,
  input  logic [23:0]               delay_ticks,
  input  logic signed [15:0]        repeat_count,
  input  logic signed [7:0]         priority_req,
  output logic                      fired,
  output logic [7:0]                fired_task_id,
  output logic [1:0]                status,
  output logic [pts_pkg::CNT_W-1:0] task_count,
  output logic                      last
);
  logic [pts_pkg::TIME_W-1:0] cur_time;
  logic                       paused;
  logic [pts_pkg::DEPTH-1:0]  valid;
  logic [7:0]                 s_id  [pts_pkg::DEPTH];
  logic signed [7:0]          s_pri [pts_pkg::DEPTH];
  logic [23:0]                s_dly [pts_pkg::DEPTH];
  logic signed [15:0]         s_rep [pts_pkg::DEPTH];
  logic [pts_pkg::TIME_W-1:0] s_due [pts_pkg::DEPTH];
  logic [7:0]                 fbuf  [pts_pkg::DEPTH];

  logic [pts_pkg::IDX_W-1:0]  scan_idx, best_idx, rd_addr, free_idx;
  logic                       found, has_free, better, keep;
  logic signed [7:0]          best_pri;
  logic [pts_pkg::TIME_W-1:0] best_due, due_next;
  logic [pts_pkg::CNT_W-1:0]  nfired, emit_idx;
  logic [1:0]                 st, add_st;
  logic signed [15:0]         new_rep;

  assign rd_addr = cmd.scan ? scan_idx : best_idx;
  assign better  = valid[rd_addr] && (!found || s_pri[rd_addr] > best_pri ||
                   (s_pri[rd_addr] == best_pri && s_due[rd_addr] < best_due));
  assign new_rep  = (s_rep[rd_addr] > 16'sd0) ? s_rep[rd_addr] - 16'sd1 : s_rep[rd_addr];
  assign keep     = new_rep > 16'sd0;
  assign due_next = cur_time + {{(pts_pkg::TIME_W-24){1'b0}}, s_dly[rd_addr]};

  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = pts_pkg::DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        has_free = 1'b1;
        free_idx = pts_pkg::IDX_W'(i);
      end
    end
    if (delay_ticks == 24'd0)          add_st = pts_pkg::ST_ZERO_DLY;
    else if (repeat_count < -16'sd1)   add_st = pts_pkg::ST_BAD_REP;
    else if (!has_free)                add_st = pts_pkg::ST_FULL;
    else                               add_st = pts_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time <= '0;
      paused   <= 1'b0;
      valid    <= '0;
      found    <= 1'b0;
      scan_idx <= '0;
      nfired   <= '0;
      emit_idx <= '0;
      st       <= pts_pkg::ST_OK;
    end else begin
      if (cfg_we) paused <= cfg_wdata;
      if (cmd.accept) begin
        nfired   <= '0;
        emit_idx <= '0;
        scan_idx <= '0;
        found    <= 1'b0;
        st       <= pts_pkg::ST_OK;
        case (mode)
          pts_pkg::MODE_ADD: begin
            st <= add_st;
            if (add_st == pts_pkg::ST_OK) begin
              valid[free_idx] <= 1'b1;
              s_id[free_idx]  <= task_id;
              s_pri[free_idx] <= priority_req;
              s_dly[free_idx] <= delay_ticks;
              s_rep[free_idx] <= repeat_count;
              s_due[free_idx] <= cur_time + {{(pts_pkg::TIME_W-24){1'b0}}, delay_ticks};
            end
          end
          pts_pkg::MODE_TICK:   cur_time <= cur_time + 1'b1;
          pts_pkg::MODE_CANCEL: valid <= '0;
          default: ;
        endcase
      end
      if (cmd.scan) begin
        // take slot as new top when it wins on priority, then due time
        if (better) begin
          found    <= 1'b1;
          best_idx <= scan_idx;
          best_pri <= s_pri[rd_addr];
          best_due <= s_due[rd_addr];
        end
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmd.fire) begin
        fbuf[nfired[pts_pkg::IDX_W-1:0]] <= s_id[rd_addr];
        nfired <= nfired + 1'b1;
        found  <= 1'b0;
        s_rep[rd_addr] <= new_rep;
        if (keep) s_due[rd_addr] <= due_next;
        else      valid[rd_addr] <= 1'b0;
      end
      if (cmd.advance) emit_idx <= emit_idx + 1'b1;
    end
  end

  always_comb begin
    sts.tick_go   = (mode == pts_pkg::MODE_TICK) && !paused;
    sts.scan_last = (scan_idx == pts_pkg::IDX_W'(pts_pkg::DEPTH - 1));
    sts.top_due   = found && !(cur_time < best_due);
    sts.buf_full  = (nfired == pts_pkg::CNT_W'(pts_pkg::DEPTH));
    sts.out_last  = (emit_idx == nfired);
  end

  assign fired         = emit_idx < nfired;
  assign fired_task_id = fired ? fbuf[emit_idx[pts_pkg::IDX_W-1:0]] : 8'd0;
  assign last          = (emit_idx == nfired);
  assign status        = last ? st : pts_pkg::ST_OK;
  assign task_count    = pts_pkg::CNT_W'($countones(valid));
endmodule

/* rtl/priority_timer_task_scheduler.sv */
// Timer task table with 16 slots and a 48-bit tick counter. One request is
// handled at a time. Add (mode 0) and cancel-all (mode 2) return one result
// with last=1. A tick (mode 1) advances time, then unless paused repeatedly
// scans all slots, one slot per cycle through a single compare unit, to find
// the top task (highest priority, earliest due time, lowest slot), and fires
// it if due. Once scanning stops, results are returned one per accepted
// output cycle: one firing result (fired=1) per fired task, then a closing
// one with last=1. task_count is the table occupancy after the whole
// request. Write cfg_wdata with cfg_we to set the paused bit; do so only
// while idle.
module priority_timer_task_scheduler (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                mode,
  input  logic [7:0]                task_id,
  input  logic [23:0]               delay_ticks,
  input  logic signed [15:0]        repeat_count,
  input  logic signed [7:0]         priority_req,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      fired,
  output logic [7:0]                fired_task_id,
  output logic [1:0]                status,
  output logic [pts_pkg::CNT_W-1:0] task_count,
  output logic                      last
);
  pts_pkg::cmd_t cmd;
  pts_pkg::sts_t sts;

  // sequence scan, fire and result return
  pts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  // hold the table, time, fired list and result fields
  pts_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .mode(mode), .task_id(task_id),
    .delay_ticks(delay_ticks), .repeat_count(repeat_count),
    .priority_req(priority_req), .fired(fired), .fired_task_id(fired_task_id),
    .status(status), .task_count(task_count), .last(last)
  );
endmodule

/* sim/tb_priority_timer_task_scheduler.sv */
module tb_priority_timer_task_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TMO_CYCLES = 20000;

  typedef struct packed {
    logic       fired;
    logic [7:0] id;
    logic [1:0] status;
    logic [4:0] count;
    logic       last;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode = pts_pkg::MODE_TICK;
  logic [7:0] task_id = '0;
  logic [23:0] delay_ticks = '0;
  logic signed [15:0] repeat_count = '0;
  logic signed [7:0] priority_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic fired;
  logic [7:0] fired_task_id;
  logic [1:0] status;
  logic [pts_pkg::CNT_W-1:0] task_count;
  logic last;

  // Predictor state: a private copy of the task table and the clock.
  logic [pts_pkg::TIME_W-1:0] now_ticks;
  logic                       tbl_used [pts_pkg::DEPTH];
  logic [7:0]                 tbl_id [pts_pkg::DEPTH];
  logic signed [7:0]          tbl_prio [pts_pkg::DEPTH];
  logic [23:0]                tbl_delay [pts_pkg::DEPTH];
  logic signed [15:0]         tbl_reps [pts_pkg::DEPTH];
  logic [pts_pkg::TIME_W-1:0] tbl_due [pts_pkg::DEPTH];
  logic                       hold_firing;

  sched_result_t expected_results[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  int  rx_hold_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  priority_timer_task_scheduler u_top (.*);

  // Count tasks currently held in the predictor's table.
  function automatic logic [4:0] held_tasks();
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < pts_pkg::DEPTH; i++) if (tbl_used[i]) n++;
    return n;
  endfunction

  // Highest priority, then earliest due, then lowest slot; -1 when empty.
  function automatic int top_task_slot();
    int b;
    b = -1;
    for (int i = 0; i < pts_pkg::DEPTH; i++) begin
      if (!tbl_used[i]) continue;
      if (b < 0 || tbl_prio[i] > tbl_prio[b] ||
          (tbl_prio[i] == tbl_prio[b] && tbl_due[i] < tbl_due[b])) b = i;
    end
    return b;
  endfunction

  // Apply one request to the predictor and queue the results it causes.
  task automatic schedule_predict(input logic [1:0] m, input logic [7:0] id,
                                  input logic [23:0] dly, input logic signed [15:0] rep,
                                  input logic signed [7:0] pri);
    sched_result_t fires[$];
    sched_result_t r;
    logic [1:0] st;
    int s, free_slot;
    st = pts_pkg::ST_OK;
    if (m == pts_pkg::MODE_ADD) begin
      if (dly == 0) st = pts_pkg::ST_ZERO_DLY;
      else if (rep < -1) st = pts_pkg::ST_BAD_REP;
      else begin
        free_slot = -1;
        for (int i = pts_pkg::DEPTH - 1; i >= 0; i--) if (!tbl_used[i]) free_slot = i;
        if (free_slot < 0) st = pts_pkg::ST_FULL;
        else begin
          tbl_used[free_slot] = 1'b1;
          tbl_id[free_slot] = id;
          tbl_prio[free_slot] = pri;
          tbl_delay[free_slot] = dly;
          tbl_reps[free_slot] = rep;
          tbl_due[free_slot] = now_ticks + dly;
        end
      end
    end else if (m == pts_pkg::MODE_TICK) begin
      now_ticks = now_ticks + 1'b1;
      if (!hold_firing) begin
        for (int k = 0; k < pts_pkg::DEPTH; k++) begin
          s = top_task_slot();
          // Stop on the first top task that is not yet due.
          if (s < 0 || now_ticks < tbl_due[s]) break;
          r = '{1'b1, tbl_id[s], pts_pkg::ST_OK, 5'd0, 1'b0};
          fires.push_back(r);
          if (tbl_reps[s] > 0) tbl_reps[s]--;
          if (tbl_reps[s] > 0) tbl_due[s] = now_ticks + tbl_delay[s];
          else tbl_used[s] = 1'b0;
        end
      end
    end else if (m == pts_pkg::MODE_CANCEL) begin
      for (int i = 0; i < pts_pkg::DEPTH; i++) tbl_used[i] = 1'b0;
    end
    foreach (fires[i]) begin
      fires[i].count = held_tasks();
      expected_results.push_back(fires[i]);
    end
    r = '{1'b0, 8'd0, st, held_tasks(), 1'b1};
    expected_results.push_back(r);
  endtask

  // Send one request, predict it at acceptance, then idle a random gap.
  task automatic send_request(input logic [1:0] m, input logic [7:0] id,
                              input logic [23:0] dly, input logic signed [15:0] rep,
                              input logic signed [7:0] pri);
    int gap;
    in_valid <= 1'b1;
    mode <= m;
    task_id <= id;
    delay_ticks <= dly;
    repeat_count <= rep;
    priority_req <= pri;
    do @(posedge clk); while (!in_ready);
    schedule_predict(m, id, dly, rep, pri);
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    send_request(pts_pkg::MODE_TICK, 8'($urandom), 24'($urandom), 16'($urandom),
                 8'($urandom));
  endtask

  task automatic send_cancel();
    send_request(pts_pkg::MODE_CANCEL, 8'd0, 24'd0, 16'sd0, 8'sd0);
  endtask

  // Drop valid, wait until every expected result has arrived, then settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Write the paused bit while idle.
  task automatic set_paused(input logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    hold_firing = v;
    cfg_we <= 1'b0;
  endtask

  // Receiver: a random wait before each result, or a long hold-off when asked.
  initial begin
    int gap;
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready) && rx_hold_cycles == 0);
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    sched_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: fired=%0d id=%0d", fired, fired_task_id);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (fired !== exp_r.fired) begin
          $error("fired: expected %0d, got %0d", exp_r.fired, fired); error_count++;
        end
        if (fired_task_id !== exp_r.id) begin
          $error("fired_task_id: expected %0d, got %0d", exp_r.id, fired_task_id);
          error_count++;
        end
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status); error_count++;
        end
        if (task_count !== exp_r.count) begin
          $error("task_count: expected %0d, got %0d", exp_r.count, task_count);
          error_count++;
        end
        if (last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, last); error_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= TMO_CYCLES) begin
        $display("** priority_timer_task_scheduler: FAILED **");
        $finish;
      end
    end
  end

  // Bad arguments, edge values of every field, full table, cancel.
  task automatic test_directed_adds();
    send_request(pts_pkg::MODE_ADD, 8'hFF, 24'd0, 16'sd5, 8'sd0);
    send_request(pts_pkg::MODE_ADD, 8'h00, 24'd1, -16'sd2, 8'sd0);
    send_request(pts_pkg::MODE_ADD, 8'h00, 24'd0, -16'sd32768, 8'sd0);
    send_request(pts_pkg::MODE_ADD, 8'hAA, 24'hFFFFFF, 16'sd32767, 8'sd127);
    send_request(pts_pkg::MODE_ADD, 8'h55, 24'd1, -16'sd1, -8'sd128);
    send_request(pts_pkg::MODE_ADD, 8'h0F, 24'd1, 16'sd0, -8'sd128);
    for (int i = 0; i < 14; i++) send_request(pts_pkg::MODE_ADD, 8'(i), 24'd3, 16'sd1, 8'sd0);
    send_request(pts_pkg::MODE_ADD, 8'h77, 24'd2, 16'sd1, 8'sd5);
    send_request(pts_pkg::MODE_SPARE, 8'h12, 24'd4, 16'sd1, 8'sd1);
    send_cancel();
  endtask

  // A due low-priority task held back behind a high-priority one; repeats.
  task automatic test_held_back_and_repeat();
    send_request(pts_pkg::MODE_ADD, 8'd1, 24'd5, 16'sd1, 8'sd100);
    send_request(pts_pkg::MODE_ADD, 8'd2, 24'd1, 16'sd3, -8'sd100);
    send_request(pts_pkg::MODE_ADD, 8'd3, 24'd2, 16'sd2, -8'sd100);
    repeat (10) send_tick();
    send_cancel();
  endtask

  // Time advances while paused; due tasks fire once unpaused.
  task automatic test_paused();
    send_request(pts_pkg::MODE_ADD, 8'd9, 24'd1, 16'sd2, 8'sd0);
    set_paused(1'b1);
    repeat (3) send_tick();
    set_paused(1'b0);
    repeat (3) send_tick();
  endtask

  // Long receiver hold-off while requests keep coming.
  task automatic test_backpressure();
    rx_hold_cycles = 200;
    for (int i = 0; i < 8; i++) begin
      send_request(pts_pkg::MODE_ADD, 8'(i), 24'd1, 16'sd2, 8'(i));
    end
    repeat (6) send_tick();
    send_cancel();
  endtask

  // Mostly short adds and ticks so tasks fire often; a little noise.
  task automatic test_random(input int n);
    int pick;
    logic [23:0] dly;
    logic signed [15:0] rep;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      dly = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(1, 6));
      if ($urandom_range(0, 9) == 0) rep = 16'($urandom);
      else rep = 16'($urandom_range(0, 4) - 1);
      if (pick < 40) begin
        send_request(pts_pkg::MODE_ADD, 8'($urandom), dly, rep, 8'($urandom));
      end else if (pick < 93) begin
        send_tick();
      end else if (pick < 97) begin
        send_request(pts_pkg::MODE_CANCEL, 8'($urandom), 24'($urandom), 16'($urandom),
                     8'($urandom));
      end else begin
        send_request(pts_pkg::MODE_SPARE, 8'($urandom), 24'($urandom), 16'($urandom),
                     8'($urandom));
      end
      if (i == n / 2) begin
        set_paused(1'b1);
        repeat (4) send_tick();
        set_paused(1'b0);
      end
    end
  endtask

  initial begin
    now_ticks = '0;
    hold_firing = 1'b0;
    for (int i = 0; i < pts_pkg::DEPTH; i++) tbl_used[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_adds();
    test_held_back_and_repeat();
    test_paused();
    test_backpressure();
    test_random(240);
    drain();
    if (error_count == 0) $display("** priority_timer_task_scheduler: PASSED **");
    else $display("** priority_timer_task_scheduler: FAILED **");
    $finish;
  end
endmodule
